// ===== rtl/srdo_pkg.sv =====
`timescale 1ns / 1ps

package srdo_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAME_W  = 7;
  localparam int COUNT_W  = 10;
  localparam int DROP_W   = 32;
  localparam int STATUS_W = 3;

  // operation codes
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_WRITTEN = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_SAMPLE  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic [FRAME_W-1:0]         frame_length;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last;
    logic [STATUS_W-1:0]        status;
    logic [COUNT_W-1:0]         used_count;
    logic [COUNT_W-1:0]         free_count;
    logic [DROP_W-1:0]          dropped_count;
  } out_t;

endpackage

// ===== rtl/srdo_ram.sv =====
`timescale 1ns / 1ps

module srdo_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sample_ring_drop_oldest_core.sv =====
`timescale 1ns / 1ps

// Ring FIFO of signed 16-bit samples that drops the oldest sample on overflow.
// Input channel (in_valid/in_ready/in_data) carries one operation per beat:
// write one sample, read a frame, or clear. Result channel (out_valid/
// out_ready/out_data) returns one beat per write, clear or refused read, and
// frame_length beats for a granted read, with last set on the final beat.
// Every result beat carries used, free and dropped counts after its effect.
// A write, clear or refused read has its result registered, and it appears
// the cycle after acceptance. A granted read streams one sample per cycle
// while the output buffer has room, through the registered read port of
// the sample memory. The next operation is accepted once all beats of the
// previous one have left the read pipeline and the output register is free
// or draining. A stalled receiver holds the output register; a two-entry
// buffer (output register plus skid) absorbs the in-flight memory read, and
// reads resume when the receiver takes data again. Reset empties the ring
// and zeroes the drop counter; the sample memory itself is not cleared.
module sample_ring_drop_oldest_core #(
  parameter int DEPTH     = 1024,
  parameter int MAX_FRAME = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  srdo_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output srdo_pkg::out_t  out_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = (AW > srdo_pkg::COUNT_W) ? AW : srdo_pkg::COUNT_W;
  localparam int CMPW = (AW > srdo_pkg::FRAME_W) ? AW : srdo_pkg::FRAME_W;

  typedef enum logic {ST_IDLE, ST_READ} state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 head_r, head_nxt;
  logic [AW-1:0]                 tail_r, tail_nxt;
  logic [srdo_pkg::DROP_W-1:0]   drop_r, drop_nxt;
  logic [srdo_pkg::FRAME_W-1:0]  rem_r, rem_nxt;
  logic                          out_valid_r, out_valid_nxt;
  srdo_pkg::out_t                out_r, out_nxt;
  logic                          skid_v_r, skid_v_nxt;
  srdo_pkg::out_t                skid_r, skid_nxt;
  logic                          pend_r;
  srdo_pkg::out_t                pend_res_r, pend_res_nxt;

  logic                          pop, acc, issue, load_ok;
  logic [1:0]                    occ;
  logic [AW-1:0]                 held, head_inc, tail_inc;
  logic                          len_bad;
  logic                          new_res_v;
  srdo_pkg::out_t                new_res, ret_res;
  logic                          mem_we;
  logic [srdo_pkg::SAMPLE_W-1:0] mem_rdata;

  // build a result beat from the ring pointers it leaves behind
  function automatic srdo_pkg::out_t make_res(
    input logic [AW-1:0]                 h,
    input logic [AW-1:0]                 t,
    input logic                          l,
    input logic [srdo_pkg::STATUS_W-1:0] st,
    input logic [srdo_pkg::DROP_W-1:0]   d
  );
    srdo_pkg::out_t r;
    logic [CW-1:0]  used_w;
    logic [CW-1:0]  free_w;
    used_w          = CW'(AW'(h - t));
    free_w          = CW'(DEPTH - 1) - used_w;
    r.sample_out    = '0;
    r.last          = l;
    r.status        = st;
    r.used_count    = used_w[srdo_pkg::COUNT_W-1:0];
    r.free_count    = free_w[srdo_pkg::COUNT_W-1:0];
    r.dropped_count = d;
    return r;
  endfunction

  srdo_ram #(
    .WIDTH (srdo_pkg::SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (head_r),
    .wdata (in_data.sample_in),
    .re    (issue),
    .raddr (tail_r),
    .rdata (mem_rdata)
  );

  // handshake and occupancy of output register, skid and in-flight read
  assign pop      = out_valid_r && out_ready;
  assign load_ok  = !out_valid_r || out_ready;
  assign occ      = 2'(out_valid_r) + 2'(skid_v_r) + 2'(pend_r);
  assign in_ready = (state_r == ST_IDLE) && !pend_r && !skid_v_r && load_ok;
  assign acc      = in_valid && in_ready;
  assign issue    = (state_r == ST_READ) && ((occ - 2'(pop)) < 2'd2);

  assign held     = head_r - tail_r;
  assign head_inc = head_r + AW'(1);
  assign tail_inc = tail_r + AW'(1);
  assign len_bad  = (in_data.frame_length == '0)
                 || (CMPW'(in_data.frame_length) > CMPW'(MAX_FRAME))
                 || (CMPW'(in_data.frame_length) > CMPW'(held));
  assign mem_we   = acc && (in_data.func == srdo_pkg::FUNC_WRITE);

  always_comb begin
    ret_res            = pend_res_r;
    ret_res.sample_out = mem_rdata;
  end

  // decode the accepted operation and advance the read stream
  always_comb begin
    state_nxt    = state_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    drop_nxt     = drop_r;
    rem_nxt      = rem_r;
    new_res_v    = 1'b0;
    new_res      = make_res(head_r, tail_r, 1'b1, srdo_pkg::ST_REFUSED, drop_r);
    pend_res_nxt = pend_res_r;

    if (acc) begin
      case (in_data.func)
        srdo_pkg::FUNC_WRITE: begin
          head_nxt  = head_inc;
          new_res_v = 1'b1;
          if (head_inc == tail_r) begin
            tail_nxt = tail_inc;
            drop_nxt = drop_r + srdo_pkg::DROP_W'(1);
            new_res  = make_res(head_inc, tail_inc, 1'b1, srdo_pkg::ST_DROPPED,
                                drop_r + srdo_pkg::DROP_W'(1));
          end else begin
            new_res  = make_res(head_inc, tail_r, 1'b1, srdo_pkg::ST_WRITTEN, drop_r);
          end
        end
        srdo_pkg::FUNC_READ: begin
          if (len_bad) begin
            new_res_v = 1'b1;
          end else begin
            state_nxt = ST_READ;
            rem_nxt   = in_data.frame_length;
          end
        end
        srdo_pkg::FUNC_CLEAR: begin
          tail_nxt  = head_r;
          new_res_v = 1'b1;
          new_res   = make_res(head_r, head_r, 1'b1, srdo_pkg::ST_CLEARED, drop_r);
        end
        default: begin
        end
      endcase
    end

    // issue one sample read per cycle while the buffer has room
    if (issue) begin
      tail_nxt     = tail_inc;
      rem_nxt      = rem_r - srdo_pkg::FRAME_W'(1);
      pend_res_nxt = make_res(head_r, tail_inc, rem_r == srdo_pkg::FRAME_W'(1),
                              srdo_pkg::ST_SAMPLE, drop_r);
      if (rem_r == srdo_pkg::FRAME_W'(1)) begin
        state_nxt = ST_IDLE;
      end
    end
  end

  // steer results into the output register, spilling to skid on stall
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    skid_nxt      = skid_r;
    skid_v_nxt    = skid_v_r;
    if (load_ok) begin
      if (skid_v_r) begin
        out_nxt       = skid_r;
        out_valid_nxt = 1'b1;
        skid_nxt      = ret_res;
        skid_v_nxt    = pend_r;
      end else if (pend_r) begin
        out_nxt       = ret_res;
        out_valid_nxt = 1'b1;
      end else if (new_res_v) begin
        out_nxt       = new_res;
        out_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (pend_r) begin
      skid_nxt   = ret_res;
      skid_v_nxt = 1'b1;
    end
  end

  // hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      drop_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      drop_r      <= drop_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
      skid_v_r    <= skid_v_nxt;
      pend_r      <= issue;
    end
    out_r      <= out_nxt;
    skid_r     <= skid_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== dv/sample_ring_drop_oldest_core_tb.sv =====
`timescale 1ns / 1ps

// Tracks the ring contents and queues the result beats each operation must produce.
class ring_scoreboard #(int RING_DEPTH = 1024, int FRAME_MAX = 64);
  localparam int IDX_W = $clog2(RING_DEPTH);

  logic [srdo_pkg::SAMPLE_W-1:0] ring_mem [RING_DEPTH];
  logic [IDX_W-1:0]              head_idx;
  logic [IDX_W-1:0]              tail_idx;
  logic [srdo_pkg::DROP_W-1:0]   drop_total;
  srdo_pkg::out_t                expected_beats[$];
  int unsigned                   errors;

  function new();
    head_idx   = '0;
    tail_idx   = '0;
    drop_total = '0;
    errors     = 0;
  endfunction

  function int unsigned held();
    logic [IDX_W-1:0] diff;
    diff = head_idx - tail_idx;
    return int'(diff);
  endfunction

  // Queue one beat carrying the counts as they stand after its effect.
  function void queue_beat(logic [srdo_pkg::SAMPLE_W-1:0] sample, logic last,
                           logic [srdo_pkg::STATUS_W-1:0] status);
    srdo_pkg::out_t beat;
    int unsigned    used;
    used               = held();
    beat.sample_out    = sample;
    beat.last          = last;
    beat.status        = status;
    beat.used_count    = srdo_pkg::COUNT_W'(used);
    beat.free_count    = srdo_pkg::COUNT_W'(RING_DEPTH - 1 - used);
    beat.dropped_count = drop_total;
    expected_beats.push_back(beat);
  endfunction

  // Advance the ring for one accepted operation.
  function void note_input(srdo_pkg::in_t item);
    logic [IDX_W-1:0]              next_head;
    logic [srdo_pkg::STATUS_W-1:0] status;
    logic [srdo_pkg::SAMPLE_W-1:0] sample;
    int unsigned                   len;
    len = item.frame_length;
    case (item.func)
      srdo_pkg::FUNC_WRITE: begin
        status    = srdo_pkg::ST_WRITTEN;
        next_head = head_idx + IDX_W'(1);
        // full ring: drop the oldest sample to make room
        if (next_head == tail_idx) begin
          tail_idx   = tail_idx + IDX_W'(1);
          drop_total = drop_total + srdo_pkg::DROP_W'(1);
          status     = srdo_pkg::ST_DROPPED;
        end
        ring_mem[head_idx] = item.sample_in;
        head_idx           = next_head;
        queue_beat('0, 1'b1, status);
      end
      srdo_pkg::FUNC_READ: begin
        if (len == 0 || len > FRAME_MAX || len > held()) begin
          queue_beat('0, 1'b1, srdo_pkg::ST_REFUSED);
        end else begin
          for (int i = 0; i < len; i++) begin
            sample   = ring_mem[tail_idx];
            tail_idx = tail_idx + IDX_W'(1);
            queue_beat(sample, i == len - 1, srdo_pkg::ST_SAMPLE);
          end
        end
      end
      srdo_pkg::FUNC_CLEAR: begin
        tail_idx = head_idx;
        queue_beat('0, 1'b1, srdo_pkg::ST_CLEARED);
      end
      default: ;  // unused code: no beats, ring untouched
    endcase
  endfunction

  task flag_mismatch(string what, logic [srdo_pkg::DROP_W-1:0] got,
                     logic [srdo_pkg::DROP_W-1:0] want);
    errors++;
    $display("mismatch %s at %0t ns: got 0x%0h, expected 0x%0h", what, $time, got, want);
  endtask

  // Compare one result beat with the oldest expected beat.
  task check_result(srdo_pkg::out_t got);
    srdo_pkg::out_t want;
    if (expected_beats.size() == 0) begin
      flag_mismatch("unexpected result beat, status", got.status, '0);
      return;
    end
    want = expected_beats.pop_front();
    if (got.sample_out !== want.sample_out)
      flag_mismatch("sample_out", got.sample_out, want.sample_out);
    if (got.last !== want.last)
      flag_mismatch("last", got.last, want.last);
    if (got.status !== want.status)
      flag_mismatch("status", got.status, want.status);
    if (got.used_count !== want.used_count)
      flag_mismatch("used_count", got.used_count, want.used_count);
    if (got.free_count !== want.free_count)
      flag_mismatch("free_count", got.free_count, want.free_count);
    if (got.dropped_count !== want.dropped_count)
      flag_mismatch("dropped_count", got.dropped_count, want.dropped_count);
  endtask
endclass

module sample_ring_drop_oldest_core_tb;

  localparam int DEPTH       = 1024;
  localparam int MAX_FRAME   = 64;
  localparam int CYCLE_LIMIT = 600_000;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 20;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  srdo_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  srdo_pkg::out_t out_data;

  int unsigned send_gap_pct  = 12;
  int unsigned recv_gap_pct  = 45;
  logic        stall_request = 1'b0;
  int unsigned stall_left    = 0;
  int unsigned cycle_count   = 0;

  ring_scoreboard #(.RING_DEPTH(DEPTH), .FRAME_MAX(MAX_FRAME)) sb;

  sample_ring_drop_oldest_core #(
    .DEPTH    (DEPTH),
    .MAX_FRAME(MAX_FRAME)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Sample both channels at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_data);
      if (out_valid && out_ready)
        sb.check_result(out_data);
    end
  end

  // Drive out_ready: long hold-off on request, otherwise random stalls.
  always @(negedge clk) begin
    if (stall_request) begin
      stall_left    = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  function automatic srdo_pkg::in_t make_op(logic [1:0] func,
                                            logic [srdo_pkg::SAMPLE_W-1:0] sample,
                                            logic [srdo_pkg::FRAME_W-1:0] len);
    srdo_pkg::in_t item;
    item.func         = func;
    item.sample_in    = sample;
    item.frame_length = len;
    return item;
  endfunction

  // Mostly well-formed writes and reads, some refused reads, clears and unused codes.
  function automatic srdo_pkg::in_t random_item();
    int unsigned pick;
    int unsigned held_now;
    int unsigned len;
    pick     = $urandom_range(0, 99);
    held_now = sb.held();
    if (pick < 50)
      return make_op(srdo_pkg::FUNC_WRITE, 16'($urandom), 7'($urandom));
    if (pick < 88) begin
      if (held_now != 0 && $urandom_range(0, 99) < 80)
        len = $urandom_range(1, (held_now < MAX_FRAME) ? held_now : MAX_FRAME);
      else
        len = $urandom_range(0, 127);
      return make_op(srdo_pkg::FUNC_READ, 16'($urandom), srdo_pkg::FRAME_W'(len));
    end
    if (pick < 95)
      return make_op(srdo_pkg::FUNC_CLEAR, 16'($urandom), 7'($urandom));
    return make_op(FUNC_UNUSED, 16'($urandom), 7'($urandom));
  endfunction

  // Offer one beat, called and returning at a falling edge; valid stays up between items unless a random gap drops it.
  task automatic send_item(input srdo_pkg::in_t item);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes, refusals, unused code, clear.
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd1));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh7FFF, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh8000, 7'd127));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh0000, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'shFFFF, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh5555, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'shAAAA, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'shFFFF, 7'd127));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd65));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd64));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd7));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd6));
    send_item(make_op(FUNC_UNUSED, 16'sh0000, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh0001, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh0002, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_CLEAR, 16'shFFFF, 7'd127));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd1));
    send_item(make_op(srdo_pkg::FUNC_WRITE, 16'sh1234, 7'd0));
    send_item(make_op(srdo_pkg::FUNC_READ, 16'sh0000, 7'd1));
    send_item(make_op(FUNC_UNUSED, 16'shFFFF, 7'd127));

    repeat (35) send_item(random_item());

    send_gap_pct = 45;
    recv_gap_pct = 12;
    repeat (35) send_item(random_item());

    // No idling; hold the receiver off long enough to back up the input.
    send_gap_pct  = 0;
    recv_gap_pct  = 0;
    stall_request = 1'b1;
    repeat (35) send_item(random_item());
    in_valid <= 1'b0;

    while (sb.expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
